// ===== src/ipid_pkg.sv =====
// ----------------------------------------------------------------------------
// ipid_pkg
// shared types and constants of the incremental pid with target dwell block
// ----------------------------------------------------------------------------
`default_nettype none

package ipid_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KP            = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI            = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD            = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RANGE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_TIME = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_SHIFT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL_TIME    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH        = 3'd7;

    localparam logic [15:0] PHASE_SHIFT_RST = 16'd5;
    localparam logic [15:0] DWELL_TIME_RST  = 16'd400;

    localparam logic signed [17:0] INT_MAX = 18'sd1000;
    localparam logic signed [17:0] INT_MIN = -18'sd1000;
    localparam logic signed [35:0] CTL_MAX = 36'sd25600;
    localparam logic signed [35:0] CTL_MIN = -36'sd25600;

    typedef struct packed {
        logic signed [15:0] kp;
        logic signed [15:0] ki;
        logic signed [15:0] kd;
        logic        [15:0] target_range;
        logic        [7:0]  response_time;
        logic        [15:0] phase_shift;
        logic        [15:0] dwell_time;
        logic               smooth;
    } ipid_cfg_t;

    typedef struct packed {
        logic signed [32:0] p_term;
        logic signed [26:0] i_term;
        logic signed [33:0] d_term;
        logic               upd;
        logic               pulse;
        logic               clear_ctl;
    } ipid_mid_t;

endpackage

`default_nettype wire

// ===== src/ipid_front.sv =====
// ----------------------------------------------------------------------------
// ipid_front
// error, update timing, integral, dwell detector and gain products
// ----------------------------------------------------------------------------
`default_nettype none

module ipid_front (
    input  logic                clk,
    input  logic                rst_n,
    input  ipid_pkg::ipid_cfg_t cfg,
    input  logic                step,
    input  logic [31:0]         now_ms,
    input  logic signed [15:0]  setpoint,
    input  logic signed [15:0]  position,
    output ipid_pkg::ipid_mid_t mid
);

    logic [31:0]        last_upd_reg,    last_upd_next;
    logic signed [10:0] integ_reg,       integ_next;
    logic signed [16:0] prev_err_reg,    prev_err_next;
    logic signed [15:0] last_sp_reg,     last_sp_next;
    logic [31:0]        dwell_start_reg, dwell_start_next;
    logic               dwell_run_reg,   dwell_run_next;
    logic               armed_reg,       armed_next;
    ipid_pkg::ipid_mid_t mid_reg,        mid_next;

    logic signed [16:0] err;
    logic        [16:0] mag;
    logic               on_tgt;
    logic [31:0]        dwell_diff;
    logic [31:0]        gap;
    logic               upd;
    logic signed [17:0] isum;
    logic signed [10:0] isum_clamped;
    logic signed [17:0] delta;
    logic               sp_chg;

    assign err        = 17'(setpoint) - 17'(position);
    assign mag        = err[16] ? 17'(-err) : 17'(err);
    assign on_tgt     = mag < {1'b0, cfg.target_range};
    assign dwell_diff = now_ms - dwell_start_reg;
    assign gap        = now_ms - last_upd_reg - {16'b0, cfg.phase_shift};
    assign upd        = gap > {24'b0, cfg.response_time};
    assign isum       = 18'(integ_reg) + 18'(err);
    assign delta      = 18'(err) - 18'(prev_err_reg);
    assign sp_chg     = setpoint != last_sp_reg;

    always_comb
    begin
        priority if (isum > ipid_pkg::INT_MAX)
        begin
            isum_clamped = 11'(ipid_pkg::INT_MAX);
        end
        else if (isum < ipid_pkg::INT_MIN)
        begin
            isum_clamped = 11'(ipid_pkg::INT_MIN);
        end
        else
        begin
            isum_clamped = isum[10:0];
        end
    end

    always_comb
    begin
        dwell_run_next   = dwell_run_reg;
        dwell_start_next = dwell_start_reg;
        armed_next       = armed_reg;
        last_upd_next    = last_upd_reg;
        integ_next       = integ_reg;
        prev_err_next    = prev_err_reg;
        last_sp_next     = last_sp_reg;

        mid_next.p_term    = 33'(cfg.kp) * 33'(err);
        mid_next.i_term    = 27'(cfg.ki) * 27'(isum_clamped);
        mid_next.d_term    = 34'(cfg.kd) * 34'(delta);
        mid_next.upd       = upd;
        mid_next.pulse     = 1'b0;
        mid_next.clear_ctl = upd && sp_chg && !cfg.smooth;

        // dwell detector
        if (on_tgt)
        begin
            if (!dwell_run_reg)
            begin
                dwell_run_next   = 1'b1;
                dwell_start_next = now_ms;
                armed_next       = 1'b1;
            end
            else if (dwell_diff > {16'b0, cfg.dwell_time})
            begin
                if (armed_reg)
                begin
                    mid_next.pulse = 1'b1;
                    armed_next     = 1'b0;
                end
            end
        end
        else
        begin
            dwell_run_next   = 1'b0;
            dwell_start_next = '0;
        end

        // pid step
        if (upd)
        begin
            integ_next    = sp_chg ? '0 : isum_clamped;
            prev_err_next = err;
            last_sp_next  = setpoint;
            last_upd_next = now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_upd_reg    <= '0;
            integ_reg       <= '0;
            prev_err_reg    <= '0;
            last_sp_reg     <= '0;
            dwell_start_reg <= '0;
            dwell_run_reg   <= 1'b0;
            armed_reg       <= 1'b1;
        end
        else if (step)
        begin
            last_upd_reg    <= last_upd_next;
            integ_reg       <= integ_next;
            prev_err_reg    <= prev_err_next;
            last_sp_reg     <= last_sp_next;
            dwell_start_reg <= dwell_start_next;
            dwell_run_reg   <= dwell_run_next;
            armed_reg       <= armed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid = mid_reg;

endmodule

`default_nettype wire

// ===== src/ipid_accum.sv =====
// ----------------------------------------------------------------------------
// ipid_accum
// sums the gain products into the control value and clamps it to full scale
// ----------------------------------------------------------------------------
`default_nettype none

module ipid_accum (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  ipid_pkg::ipid_mid_t mid,
    output logic signed [15:0]  control_out,
    output logic                updated,
    output logic                on_target
);

    logic signed [15:0] ctl_reg, ctl_next;
    logic signed [15:0] out_ctl_reg;
    logic               out_upd_reg;
    logic               out_tgt_reg;

    logic signed [35:0] sum;
    logic signed [15:0] ctl_clamped;

    assign sum = 36'(ctl_reg) + 36'(mid.p_term) + 36'(mid.i_term) + 36'(mid.d_term);

    always_comb
    begin
        priority if (sum > ipid_pkg::CTL_MAX)
        begin
            ctl_clamped = 16'(ipid_pkg::CTL_MAX);
        end
        else if (sum < ipid_pkg::CTL_MIN)
        begin
            ctl_clamped = 16'(ipid_pkg::CTL_MIN);
        end
        else
        begin
            ctl_clamped = sum[15:0];
        end
    end

    always_comb
    begin
        priority if (!mid.upd)
        begin
            ctl_next = ctl_reg;
        end
        else if (mid.clear_ctl)
        begin
            ctl_next = '0;
        end
        else
        begin
            ctl_next = ctl_clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (step)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_ctl_reg <= ctl_next;
            out_upd_reg <= mid.upd;
            out_tgt_reg <= mid.pulse;
        end
    end

    assign control_out = out_ctl_reg;
    assign updated     = out_upd_reg;
    assign on_target   = out_tgt_reg;

endmodule

`default_nettype wire

// ===== src/incremental_pid_with_target_dwell.sv =====
// ----------------------------------------------------------------------------
// incremental_pid_with_target_dwell
// incremental pid controller with an on-target dwell acknowledge pulse
//
// one input item per millisecond tick (now_ms, setpoint, position) on an
// in_valid / in_ready channel; one result item (control_out, updated,
// on_target) per tick on an out_valid / out_ready channel.
// gains and timing registers are written on the cfg channel (cfg_index,
// cfg_data), which is always ready; write them only while the block is idle.
// the datapath is three registers deep: input register, gain product
// register, result register; an accepted item passes through them in that
// order. one item per cycle is sustained while the receiver is ready, with
// the gain multipliers in the front stage and the accumulate-and-clamp in
// the back. a stalled receiver holds the result register; the earlier
// stages keep filling until all three hold an item, then in_ready drops.
// reset empties the pipeline and returns the cfg registers and all
// controller state to their reset values; the data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module incremental_pid_with_target_dwell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ipid_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [31:0]                   now_ms,
    input  logic signed [15:0]            setpoint,
    input  logic signed [15:0]            position,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [15:0]            control_out,
    output logic                          updated,
    output logic                          on_target
);

    ipid_pkg::ipid_cfg_t cfg_reg;
    ipid_pkg::ipid_mid_t mid;

    logic               v0_reg, v0_next;
    logic               v1_reg, v1_next;
    logic               v2_reg, v2_next;
    logic [31:0]        now_reg;
    logic signed [15:0] sp_reg;
    logic signed [15:0] pos_reg;

    logic in_fire;
    logic out_fire;
    logic s2_ready;
    logic s1_ready;
    logic s0_adv;
    logic s1_adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp            <= '0;
            cfg_reg.ki            <= '0;
            cfg_reg.kd            <= '0;
            cfg_reg.target_range  <= '0;
            cfg_reg.response_time <= '0;
            cfg_reg.phase_shift   <= ipid_pkg::PHASE_SHIFT_RST;
            cfg_reg.dwell_time    <= ipid_pkg::DWELL_TIME_RST;
            cfg_reg.smooth        <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ipid_pkg::REG_KP:            cfg_reg.kp            <= cfg_data;
                ipid_pkg::REG_KI:            cfg_reg.ki            <= cfg_data;
                ipid_pkg::REG_KD:            cfg_reg.kd            <= cfg_data;
                ipid_pkg::REG_TARGET_RANGE:  cfg_reg.target_range  <= cfg_data;
                ipid_pkg::REG_RESPONSE_TIME: cfg_reg.response_time <= cfg_data[7:0];
                ipid_pkg::REG_PHASE_SHIFT:   cfg_reg.phase_shift   <= cfg_data;
                ipid_pkg::REG_DWELL_TIME:    cfg_reg.dwell_time    <= cfg_data;
                ipid_pkg::REG_SMOOTH:        cfg_reg.smooth        <= cfg_data[0];
            endcase
        end
    end

    // pipeline flow control
    assign s2_ready = !v2_reg || out_ready;
    assign s1_ready = !v1_reg || s2_ready;
    assign s1_adv   = v1_reg && s2_ready;
    assign s0_adv   = v0_reg && s1_ready;
    assign in_ready = !v0_reg || s1_ready;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = v2_reg && out_ready;

    always_comb
    begin
        v0_next = in_fire ? 1'b1 : (s0_adv ? 1'b0 : v0_reg);
        v1_next = s0_adv ? 1'b1 : (s1_adv ? 1'b0 : v1_reg);
        v2_next = s1_adv ? 1'b1 : (out_fire ? 1'b0 : v2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            now_reg <= now_ms;
            sp_reg  <= setpoint;
            pos_reg <= position;
        end
    end

    ipid_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .step     (s0_adv),
        .now_ms   (now_reg),
        .setpoint (sp_reg),
        .position (pos_reg),
        .mid      (mid)
    );

    ipid_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_adv),
        .mid         (mid),
        .control_out (control_out),
        .updated     (updated),
        .on_target   (on_target)
    );

    assign out_valid = v2_reg;

    a_ctl_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (control_out <= 16'sd25600 && control_out >= -16'sd25600))
        else $error("control value beyond full scale");

    a_s0_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v0_reg && !s1_ready) |=> (v0_reg && $stable(now_reg) && $stable(sp_reg)))
        else $error("input stage lost a stalled item");

    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> v0_reg)
        else $error("accepted item not held in input stage");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(control_out)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== tb/sv/ipid_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// ipid_tb_pkg
// scoreboard for the incremental pid with target dwell block
//
// keeps its own copy of the gain and timing registers and of the controller
// state, works out the control value, update flag and dwell pulse for every
// tick taken by the block, and compares each result item with the oldest one
// still owed
// ----------------------------------------------------------------------------
package ipid_tb_pkg;

    import ipid_pkg::*;

    typedef struct {
        logic signed [15:0] control;
        logic               upd;
        logic               pulse;
    } pid_out_t;

    class pid_scoreboard;

        ipid_cfg_t   regs;
        logic [31:0] last_update_ms;
        longint      integral;
        longint      err_last;
        longint      control;
        longint      sp_held;
        logic [31:0] dwell_start_ms;
        bit          dwell_running;
        bit          ack_armed;
        pid_out_t    due_outputs[$];
        int unsigned failures;

        function new();
            regs             = '0;
            regs.phase_shift = PHASE_SHIFT_RST;
            regs.dwell_time  = DWELL_TIME_RST;
            last_update_ms   = '0;
            integral         = 0;
            err_last         = 0;
            control          = 0;
            sp_held          = 0;
            dwell_start_ms   = '0;
            dwell_running    = 1'b0;
            ack_armed        = 1'b1;
            failures         = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                REG_KP:            regs.kp = data;
                REG_KI:            regs.ki = data;
                REG_KD:            regs.kd = data;
                REG_TARGET_RANGE:  regs.target_range = data;
                REG_RESPONSE_TIME: regs.response_time = data[7:0];
                REG_PHASE_SHIFT:   regs.phase_shift = data;
                REG_DWELL_TIME:    regs.dwell_time = data;
                REG_SMOOTH:        regs.smooth = data[0];
                default: ;
            endcase
        endfunction

        static function longint clip(longint v, longint lo, longint hi);
            if (v < lo)
            begin
                return lo;
            end
            if (v > hi)
            begin
                return hi;
            end
            return v;
        endfunction

        function void note_tick(logic [31:0] now, logic signed [15:0] sp,
                                logic signed [15:0] pos);
            longint      err;
            longint      mag;
            longint      delta;
            longint      incr;
            logic [31:0] gap;
            pid_out_t    o;

            err     = longint'(sp) - longint'(pos);
            mag     = (err < 0) ? -err : err;
            o.upd   = 1'b0;
            o.pulse = 1'b0;

            // dwell detector
            if (mag < longint'(regs.target_range))
            begin
                gap = now - dwell_start_ms;
                if (!dwell_running)
                begin
                    dwell_running  = 1'b1;
                    dwell_start_ms = now;
                    ack_armed      = 1'b1;
                end
                else if (gap > 32'(regs.dwell_time) && ack_armed)
                begin
                    o.pulse   = 1'b1;
                    ack_armed = 1'b0;
                end
            end
            else
            begin
                dwell_running  = 1'b0;
                dwell_start_ms = '0;
            end

            // pid step
            gap = now - last_update_ms - 32'(regs.phase_shift);
            if (gap > 32'(regs.response_time))
            begin
                integral = clip(integral + err, longint'(INT_MIN), longint'(INT_MAX));
                delta    = err - err_last;
                err_last = err;
                incr = longint'($signed(regs.kp)) * err
                     + longint'($signed(regs.ki)) * integral
                     + longint'($signed(regs.kd)) * delta;
                control = clip(control + incr, longint'(CTL_MIN), longint'(CTL_MAX));
                if (longint'(sp) != sp_held)
                begin
                    if (!regs.smooth)
                    begin
                        control = 0;
                    end
                    integral = 0;
                    sp_held  = longint'(sp);
                end
                last_update_ms = now;
                o.upd          = 1'b1;
            end

            o.control = control[15:0];
            due_outputs.push_back(o);
        endfunction

        function void check_result(logic signed [15:0] ctl, logic upd, logic pulse);
            pid_out_t o;

            if (due_outputs.size() == 0)
            begin
                $error("result item with no tick outstanding: control_out %0d", ctl);
                failures++;
                return;
            end
            o = due_outputs.pop_front();
            if (ctl !== o.control)
            begin
                $error("control_out: expected %0d, got %0d", o.control, ctl);
                failures++;
            end
            if (upd !== o.upd)
            begin
                $error("updated: expected %0b, got %0b", o.upd, upd);
                failures++;
            end
            if (pulse !== o.pulse)
            begin
                $error("on_target: expected %0b, got %0b", o.pulse, pulse);
                failures++;
            end
        endfunction

        function int pending();
            return due_outputs.size();
        endfunction

        function void close_out();
            if (due_outputs.size() != 0)
            begin
                $error("%0d result items never arrived", due_outputs.size());
                failures += due_outputs.size();
            end
        endfunction

    endclass

endpackage

// ===== tb/sv/incremental_pid_with_target_dwell_tb.sv =====
// ----------------------------------------------------------------------------
// incremental_pid_with_target_dwell_tb
// self-checking bench for the incremental pid with target dwell block
//
// a short directed run covers the field extremes, a setpoint change with and
// without smoothing, the dwell pulse and a dwell across the wrap of the
// millisecond counter; random phases with varied gains and timing
// follow, with mostly tracking ticks near the setpoint. both channels idle at
// random, one phase runs with no idling and one pauses the sender until all
// results are back.
// ----------------------------------------------------------------------------
module incremental_pid_with_target_dwell_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ipid_pkg::*;
    import ipid_tb_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 240;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [15:0]            cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [31:0]            now_ms    = '0;
    logic signed [15:0]     setpoint  = '0;
    logic signed [15:0]     position  = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic signed [15:0]     control_out;
    logic                   updated;
    logic                   on_target;

    logic                   steady = 1'b0;
    ipid_cfg_t              cur_cfg;
    pid_scoreboard          sb;

    incremental_pid_with_target_dwell u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .now_ms      (now_ms),
        .setpoint    (setpoint),
        .position    (position),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .control_out (control_out),
        .updated     (updated),
        .on_target   (on_target)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(0, 99) >= 26);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            sb.note_tick(now_ms, setpoint, position);
        end
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(control_out, updated, on_target);
        end
    end

    initial
    begin : watchdog
        int stalled;

        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
            begin
                stalled = 0;
            end
            else
            begin
                stalled++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic ipid_cfg_t make_cfg(int kp, int ki, int kd, int range, int resp,
                                           int phase, int dwell, bit smooth);
        ipid_cfg_t c;

        c.kp            = kp[15:0];
        c.ki            = ki[15:0];
        c.kd            = kd[15:0];
        c.target_range  = range[15:0];
        c.response_time = resp[7:0];
        c.phase_shift   = phase[15:0];
        c.dwell_time    = dwell[15:0];
        c.smooth        = smooth;
        return c;
    endfunction

    task automatic send_item(logic [31:0] t, logic signed [15:0] sp,
                             logic signed [15:0] pos);
        while (!steady && $urandom_range(0, 99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        now_ms   <= t;
        setpoint <= sp;
        position <= pos;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // drop valid, then wait for every owed result and the pipeline to empty
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic post_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_config(ipid_cfg_t c);
        post_reg(REG_KP, c.kp);
        post_reg(REG_KI, c.ki);
        post_reg(REG_KD, c.kd);
        post_reg(REG_TARGET_RANGE, c.target_range);
        post_reg(REG_RESPONSE_TIME, {8'd0, c.response_time});
        post_reg(REG_PHASE_SHIFT, c.phase_shift);
        post_reg(REG_DWELL_TIME, c.dwell_time);
        post_reg(REG_SMOOTH, {15'd0, c.smooth});
        cfg_valid <= 1'b0;
        @(posedge clk);
        cur_cfg = c;
    endtask

    task automatic run_phase(int count, bit pause_mid, inout logic [31:0] tick_ms,
                             inout logic signed [15:0] sp_cur);
        int                 pick;
        int                 span;
        int                 p;
        logic signed [15:0] pos_v;

        span = (cur_cfg.target_range > 16'd3000) ? 3000 : int'(cur_cfg.target_range) + 2;
        for (int i = 0; i < count; i++)
        begin
            if (pause_mid && i == count / 2)
            begin
                settle();
            end

            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                tick_ms = tick_ms + 32'd1;
            end
            else if (pick < 92)
            begin
                tick_ms = tick_ms + $urandom_range(2, 400);
            end
            else if (pick < 97)
            begin
                tick_ms = $urandom();
            end
            else
            begin
                tick_ms = 32'hFFFF_FFFF - $urandom_range(0, 3);
            end

            if ($urandom_range(0, 99) < 4)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    sp_cur = 16'sh7FFF;
                end
                else if (pick == 1)
                begin
                    sp_cur = 16'sh8000;
                end
                else if (pick < 6)
                begin
                    sp_cur = 16'(int'($urandom_range(0, 4000)) - 2000);
                end
                else
                begin
                    sp_cur = 16'($urandom());
                end
            end

            pick = $urandom_range(0, 99);
            if (pick < 90)
            begin
                if (pick < 65)
                begin
                    p = int'(sp_cur) + int'($urandom_range(0, 2 * span)) - span;
                end
                else
                begin
                    p = int'(sp_cur) + int'($urandom_range(0, 6000)) - 3000;
                end
                if (p > 32767)
                begin
                    p = 32767;
                end
                else if (p < -32768)
                begin
                    p = -32768;
                end
                pos_v = 16'(p);
            end
            else
            begin
                pos_v = 16'($urandom());
            end

            send_item(tick_ms, sp_cur, pos_v);
        end
    endtask

    initial
    begin : stimulus
        logic [31:0]        tick_ms;
        logic signed [15:0] sp_cur;
        ipid_cfg_t          c;
        int                 pick;

        sb      = new();
        cur_cfg = sb.regs;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero gains, nothing on target
        send_item(32'd0, 16'sh7FFF, 16'sh8000);
        send_item(32'd1, 16'sh8000, 16'sh7FFF);
        settle();

        apply_config(make_cfg(256, 16, 64, 40, 0, 0, 3, 1'b0));
        send_item(32'd100, 16'sd0, 16'sd0);
        send_item(32'd101, 16'sd0, 16'sd10);
        send_item(32'd102, 16'sd0, 16'sd5);
        send_item(32'd103, 16'sd0, -16'sd7);
        send_item(32'd104, 16'sd0, 16'sd3);
        send_item(32'd105, 16'sd0, 16'sd0);
        send_item(32'd106, 16'sd0, 16'sd200);
        send_item(32'd107, 16'sd1000, 16'sd0);
        send_item(32'd108, 16'sd1000, 16'sd900);
        // dwell across the counter wrap
        send_item(32'hFFFF_FFFE, 16'sd1000, 16'sd990);
        send_item(32'hFFFF_FFFF, 16'sd1000, 16'sd995);
        send_item(32'd0, 16'sd1000, 16'sd1000);
        send_item(32'd1, 16'sd1000, 16'sd1001);
        send_item(32'd2, 16'sd1000, 16'sd998);
        send_item(32'd3, 16'sh7FFF, 16'sh8000);
        send_item(32'd4, 16'sh8000, 16'sh7FFF);
        settle();

        apply_config(make_cfg(32767, -32768, 32767, 65535, 255, 65535, 0, 1'b1));
        send_item(32'h1000_0000, 16'sd500, 16'sd500);
        send_item(32'h1000_0001, 16'sd500, 16'sd480);
        send_item(32'h1000_0000 + 32'd65791, 16'sd500, 16'sd510);
        send_item(32'h1000_0000 + 32'd131581, 16'sd500, 16'sd400);
        send_item(32'h2000_0000, 16'sd600, 16'sd450);
        send_item(32'h3000_0000, 16'sh8000, 16'sh7FFF);
        settle();

        tick_ms = 32'h4000_0000;
        sp_cur  = 16'sd0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            pick = $urandom_range(0, 3);
            c = make_cfg(int'($urandom_range(0, 1023)) - 512,
                         int'($urandom_range(0, 255)) - 128,
                         int'($urandom_range(0, 1023)) - 512,
                         $urandom_range(0, 600),
                         ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(0, 6),
                         ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(0, 8),
                         (pick == 0) ? 0 : ((pick == 1) ? 65535 : $urandom_range(1, 40)),
                         $urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0)
            begin
                c.kp = 16'($urandom());
                c.ki = 16'($urandom());
                c.kd = 16'($urandom());
            end
            if (ph == 0)
            begin
                c.kp         = 16'sh8000;
                c.kd         = 16'sh8000;
                c.dwell_time = 16'hFFFF;
            end
            apply_config(c);
            steady <= (ph == 3);
            run_phase(PHASE_ITEMS, ph == 5, tick_ms, sp_cur);
            settle();
        end

        steady <= 1'b0;
        repeat (10) @(posedge clk);
        sb.close_out();
        if (sb.failures == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
